[rtl/ssp_pkg.sv]
// Shared types and constants for the size suffix text parser.
`default_nettype none

package ssp_pkg;

	localparam int SIZE_WIDTH = 64;
	localparam int CHAR_WIDTH = 8;
	localparam int DIGIT_WIDTH = 4;

	localparam logic [CHAR_WIDTH-1:0] CHAR_NUL  = 8'h00;
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UP_T = 8'h54;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LO_T = 8'h74;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UP_G = 8'h47;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LO_G = 8'h67;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UP_M = 8'h4d;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LO_M = 8'h6d;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UP_K = 8'h4b;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LO_K = 8'h6b;
	localparam logic [CHAR_WIDTH-1:0] CHAR_UP_B = 8'h42;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LO_B = 8'h62;

	localparam int UNIT_SHIFT_T = 40;
	localparam int UNIT_SHIFT_G = 30;
	localparam int UNIT_SHIFT_M = 20;
	localparam int UNIT_SHIFT_K = 10;

	typedef enum logic [2:0] {
		UNIT_B,
		UNIT_K,
		UNIT_M,
		UNIT_G,
		UNIT_T
	} unit_t;

	typedef struct packed {
		logic                   is_nul;
		logic                   is_digit;
		logic                   is_unit;
		unit_t                  unit;
		logic [DIGIT_WIDTH-1:0] digit;
	} char_class_t;

endpackage

`default_nettype wire

[rtl/ssp_classify.sv]
// Character decoder: sorts one byte into terminator, digit, unit letter or other.
`default_nettype none

module ssp_classify import ssp_pkg::*; (
	input  wire logic [CHAR_WIDTH-1:0] character,
	output char_class_t                cls
);

	logic [CHAR_WIDTH-1:0] digit_full;

	assign digit_full = character - CHAR_ZERO;

	always_comb begin
		cls.is_nul   = (character == CHAR_NUL);
		cls.is_digit = character inside {[CHAR_ZERO:CHAR_NINE]};
		cls.digit    = digit_full[DIGIT_WIDTH-1:0];
		cls.is_unit  = 1'b1;
		cls.unit     = UNIT_B;
		case (character)
			CHAR_UP_T, CHAR_LO_T: cls.unit = UNIT_T;
			CHAR_UP_G, CHAR_LO_G: cls.unit = UNIT_G;
			CHAR_UP_M, CHAR_LO_M: cls.unit = UNIT_M;
			CHAR_UP_K, CHAR_LO_K: cls.unit = UNIT_K;
			CHAR_UP_B, CHAR_LO_B: cls.unit = UNIT_B;
			default: cls.is_unit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/ssp_accum.sv]
// Parse state: pending number, running total and stop flag, updated once per item.
`default_nettype none

module ssp_accum import ssp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire char_class_t           cls,
	output logic                       res_valid,
	output logic [SIZE_WIDTH-1:0]      res_total,
	output logic                       res_stopped
);

	logic [SIZE_WIDTH-1:0] acc_q;
	logic [SIZE_WIDTH-1:0] total_q;
	logic                  stopped_q;
	logic [SIZE_WIDTH-1:0] acc_times_ten;
	logic [SIZE_WIDTH-1:0] scaled;

	assign acc_times_ten = (acc_q << 3) + (acc_q << 1) + SIZE_WIDTH'(cls.digit);

	always_comb begin
		case (cls.unit)
			UNIT_T:  scaled = acc_q << UNIT_SHIFT_T;
			UNIT_G:  scaled = acc_q << UNIT_SHIFT_G;
			UNIT_M:  scaled = acc_q << UNIT_SHIFT_M;
			UNIT_K:  scaled = acc_q << UNIT_SHIFT_K;
			default: scaled = acc_q;
		endcase
	end

	assign res_valid   = en && cls.is_nul;
	assign res_total   = total_q + acc_q;
	assign res_stopped = stopped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			total_q   <= '0;
			stopped_q <= 1'b0;
		end else if (en) begin
			if (cls.is_nul) begin
				acc_q     <= '0;
				total_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (cls.is_digit) begin
					acc_q <= acc_times_ten;
				end else if (cls.is_unit) begin
					total_q <= total_q + scaled;
					acc_q   <= '0;
				end else begin
					// Anything else closes the term unscaled and ends parsing.
					total_q   <= total_q + acc_q;
					acc_q     <= '0;
					stopped_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/size_suffix_text_parser.sv]
// Top level of the size suffix text parser: input register, parse state and result register.
// A terminator item is captured in the input register; its result is registered on m_tvalid.
// Throughput: one item per cycle; the input register and the parse state update stall
// only while a result waits in the output register and m_tready is low.
// Reset: arst_n clears the input and output valid flags and zeroes the parse state.
`default_nettype none

module size_suffix_text_parser import ssp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [CHAR_WIDTH-1:0] s_tdata,  // [7:0] character
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [SIZE_WIDTH-1:0]      m_tdata,  // [63:0] total_size
	output logic [0:0]                 m_tuser   // [0] stopped_early
);

	logic                  valid_s1;
	logic [CHAR_WIDTH-1:0] char_s1;
	logic                  out_valid_q;
	logic [SIZE_WIDTH-1:0] out_total_q;
	logic                  out_stopped_q;
	logic                  stall;
	logic                  proc_en;
	char_class_t           cls;
	logic                  res_valid;
	logic [SIZE_WIDTH-1:0] res_total;
	logic                  res_stopped;

	assign stall    = out_valid_q && !m_tready;
	assign proc_en  = valid_s1 && !stall;
	assign s_tready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	ssp_classify u_classify (
		.character (char_s1),
		.cls       (cls)
	);

	ssp_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (proc_en),
		.cls         (cls),
		.res_valid   (res_valid),
		.res_total   (res_total),
		.res_stopped (res_stopped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_total_q   <= res_total;
			out_stopped_q <= res_stopped;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_total_q;
	assign m_tuser[0] = out_stopped_q;

endmodule

`default_nettype wire
